// ----- hdl/dwu_pkg.sv -----
// ----------------------------------------------------------------------------
// dwu_pkg
// Shared types and constants for the debug watchpoint unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dwu_pkg;

  // Register shadow geometry
  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Watch geometry
  localparam int SLOTS        = 2;
  localparam int WATCH_SPAN   = 4;
  localparam int MEM_WATCH_W  = 34;
  localparam int REG_WATCH_W  = 38;
  localparam int BREAK_W      = 25;
  localparam int CFG_DATA_W   = 38;
  localparam int CFG_IDX_W    = 3;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_MEM_WRITE  = 2'd0,
    REQ_MEM_READ   = 2'd1,
    REQ_REG_UPDATE = 2'd2,
    REQ_PC_CHECK   = 2'd3
  } req_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_WATCH_0 = 3'd0,
    CFG_MEM_WATCH_1 = 3'd1,
    CFG_REG_WATCH_0 = 3'd2,
    CFG_REG_WATCH_1 = 3'd3,
    CFG_BREAK_0     = 3'd4,
    CFG_BREAK_1     = 3'd5
  } cfg_idx_t;

  // One input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] access_address;
    logic [2:0]  access_size;
    logic [31:0] data_value;
    logic [3:0]  reg_index;
  } item_t;

  // Slot configuration
  typedef struct packed {
    logic [SLOTS-1:0][MEM_WATCH_W-1:0] mem_watch;
    logic [SLOTS-1:0][REG_WATCH_W-1:0] reg_watch;
    logic [SLOTS-1:0][BREAK_W-1:0]     brk;
  } cfg_t;

  // Last-hit record
  typedef struct packed {
    logic        valid;
    logic        source;
    logic        slot;
    logic [31:0] address;
    logic [31:0] new_value;
    logic [31:0] old_value;
    logic        is_write;
  } rec_t;

  // Comparator result for one item
  typedef struct packed {
    logic hit;
    logic rec_update;
    rec_t rec;
  } match_t;

endpackage

`default_nettype wire

// ----- hdl/dwu_req_if.sv -----
// ----------------------------------------------------------------------------
// dwu_req_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] access_address;
  logic [2:0]  access_size;
  logic [31:0] data_value;
  logic [3:0]  reg_index;

  modport source (
    output valid, req_type, access_address, access_size, data_value, reg_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, access_address, access_size, data_value, reg_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/dwu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dwu_rsp_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        last_valid;
  logic        last_source;
  logic        last_slot;
  logic [31:0] last_address;
  logic [31:0] last_new_value;
  logic [31:0] last_old_value;
  logic        last_is_write;

  modport source (
    output valid, hit, last_valid, last_source, last_slot, last_address,
           last_new_value, last_old_value, last_is_write,
    input  ready
  );
  modport sink (
    input  valid, hit, last_valid, last_source, last_slot, last_address,
           last_new_value, last_old_value, last_is_write,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/dwu_ram.sv -----
// ----------------------------------------------------------------------------
// dwu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dwu_shadow.sv -----
// ----------------------------------------------------------------------------
// dwu_shadow
// Register shadow: RAM plus per-entry valid bits (reset reads as zero) and
// forwarding of a write that lands in the same cycle as a read.
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_shadow (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [dwu_pkg::REG_IDX_W-1:0] rd_idx,
  input  wire logic                         wr_en,
  input  wire logic [dwu_pkg::REG_IDX_W-1:0] wr_idx,
  input  wire logic [31:0]                  wr_data,
  output logic      [31:0]                  old_value
);

  logic [dwu_pkg::REG_COUNT-1:0] valid;
  logic [31:0]                   ram_rdata;
  logic                          fwd;
  logic [31:0]                   fwd_data;
  logic                          entry_vld;
  logic                          fwd_now;

  dwu_ram #(
    .WIDTH (32),
    .DEPTH (dwu_pkg::REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Write in flight to the entry being read: RAM returns the old word
  assign fwd_now = wr_en && (wr_idx == rd_idx);

  // Valid bits, set on first write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Capture forwarding and validity alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd       <= 1'b0;
      entry_vld <= 1'b0;
    end else if (rd_en) begin
      fwd       <= fwd_now;
      entry_vld <= fwd_now || valid[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  always_comb begin
    if (!entry_vld) begin
      old_value = '0;
    end else if (fwd) begin
      old_value = fwd_data;
    end else begin
      old_value = ram_rdata;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dwu_match.sv -----
// ----------------------------------------------------------------------------
// dwu_match
// Slot comparators: memory range overlap, register change watch and PC
// breakpoints, with lowest-slot priority and the new record contents.
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_match (
  input  wire dwu_pkg::item_t  item,
  input  wire dwu_pkg::cfg_t   cfg,
  input  wire logic [31:0]     old_value,
  output dwu_pkg::match_t      result,
  output logic                 shadow_we
);

  dwu_pkg::req_kind_t       kind;
  logic                     is_write;
  logic [dwu_pkg::SLOTS-1:0] mem_hit;
  logic [dwu_pkg::SLOTS-1:0] reg_hit;
  logic [dwu_pkg::SLOTS-1:0] pc_hit;
  logic [32:0]              aend;
  logic                     in_range;
  logic                     changed;

  assign kind     = dwu_pkg::req_kind_t'(item.req_type);
  assign is_write = (kind == dwu_pkg::REQ_MEM_WRITE);
  assign aend     = {1'b0, item.access_address} + {30'd0, item.access_size};
  assign in_range = 32'(item.reg_index) < 32'(dwu_pkg::REG_COUNT);
  assign changed  = old_value != item.data_value;

  // Per-slot comparators
  always_comb begin
    for (int s = 0; s < dwu_pkg::SLOTS; s++) begin
      logic [31:0] waddr;
      logic [1:0]  wkind;
      logic [32:0] wend;
      logic        en;
      waddr = cfg.mem_watch[s][31:0];
      wkind = cfg.mem_watch[s][33:32];
      wend  = {1'b0, waddr} + 33'(dwu_pkg::WATCH_SPAN);
      en    = is_write ? wkind[1] : wkind[0];
      mem_hit[s] = en && ({1'b0, item.access_address} < wend) &&
                   (aend > {1'b0, waddr});
      reg_hit[s] = cfg.reg_watch[s][37] &&
                   (cfg.reg_watch[s][35:32] == item.reg_index) &&
                   (!cfg.reg_watch[s][36] ||
                    (cfg.reg_watch[s][31:0] == item.data_value));
      pc_hit[s]  = cfg.brk[s][24] &&
                   (cfg.brk[s][23:0] == item.access_address[25:2]);
    end
  end

  // Priority select and record contents
  always_comb begin
    result           = '0;
    result.rec.valid = 1'b1;
    shadow_we        = 1'b0;
    unique case (kind)
      dwu_pkg::REQ_MEM_WRITE, dwu_pkg::REQ_MEM_READ: begin
        result.hit            = |mem_hit;
        result.rec_update     = |mem_hit;
        result.rec.source     = 1'b0;
        result.rec.slot       = !mem_hit[0];
        result.rec.address    = mem_hit[0] ? cfg.mem_watch[0][31:0]
                                           : cfg.mem_watch[1][31:0];
        result.rec.new_value  = item.data_value;
        result.rec.old_value  = '0;
        result.rec.is_write   = is_write;
      end
      dwu_pkg::REQ_REG_UPDATE: begin
        shadow_we             = in_range;
        result.hit            = in_range && changed && (|reg_hit);
        result.rec_update     = result.hit;
        result.rec.source     = 1'b1;
        result.rec.slot       = !reg_hit[0];
        result.rec.address    = 32'(item.reg_index);
        result.rec.new_value  = item.data_value;
        result.rec.old_value  = old_value;
        result.rec.is_write   = 1'b1;
      end
      dwu_pkg::REQ_PC_CHECK: begin
        result.hit            = |pc_hit;
      end
      default: begin
        result.hit            = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/debug_watchpoint_unit.sv -----
// ----------------------------------------------------------------------------
// debug_watchpoint_unit
// Watchpoint and breakpoint comparator with a register shadow in RAM.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless the output stalls, and returns one
// result per item, in order. An item is registered while the register
// shadow RAM is read, then passes through the comparators, where the shadow
// is written back and the last-hit record is updated; the result then sits
// in an output register. A shadow write that coincides with a read of the
// same entry is forwarded, so back-to-back register updates see each other.
// The shadow reads as zero after reset through per-entry valid bits; no
// clearing pass is needed. The user must write the slot registers through
// cfg_we/cfg_index/cfg_wdata while the unit is idle; this is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module debug_watchpoint_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dwu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dwu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dwu_req_if.sink                             req,
  dwu_rsp_if.source                           rsp
);

  dwu_pkg::cfg_t   cfg;
  dwu_pkg::item_t  s1_item;
  logic            s1_valid;
  dwu_pkg::rec_t   rec;
  dwu_pkg::rec_t   rec_next;
  dwu_pkg::match_t match;
  logic            shadow_we;
  logic [31:0]     old_value;
  logic            commit;
  logic            accept;
  logic            out_valid;
  logic            out_hit;
  dwu_pkg::rec_t   out_rec;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (dwu_pkg::cfg_idx_t'(cfg_index))
        dwu_pkg::CFG_MEM_WATCH_0: cfg.mem_watch[0] <= cfg_wdata[dwu_pkg::MEM_WATCH_W-1:0];
        dwu_pkg::CFG_MEM_WATCH_1: cfg.mem_watch[1] <= cfg_wdata[dwu_pkg::MEM_WATCH_W-1:0];
        dwu_pkg::CFG_REG_WATCH_0: cfg.reg_watch[0] <= cfg_wdata[dwu_pkg::REG_WATCH_W-1:0];
        dwu_pkg::CFG_REG_WATCH_1: cfg.reg_watch[1] <= cfg_wdata[dwu_pkg::REG_WATCH_W-1:0];
        dwu_pkg::CFG_BREAK_0:     cfg.brk[0]       <= cfg_wdata[dwu_pkg::BREAK_W-1:0];
        dwu_pkg::CFG_BREAK_1:     cfg.brk[1]       <= cfg_wdata[dwu_pkg::BREAK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: compare stage retires when the output register frees up
  assign commit    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || commit;
  assign accept    = req.valid && req.ready;

  // Shadow read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.req_type       <= req.req_type;
      s1_item.access_address <= req.access_address;
      s1_item.access_size    <= req.access_size;
      s1_item.data_value     <= req.data_value;
      s1_item.reg_index      <= req.reg_index;
    end
  end

  dwu_shadow u_shadow (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_idx    (dwu_pkg::REG_IDX_W'(req.reg_index)),
    .wr_en     (commit && shadow_we),
    .wr_idx    (dwu_pkg::REG_IDX_W'(s1_item.reg_index)),
    .wr_data   (s1_item.data_value),
    .old_value (old_value)
  );

  // Compare stage
  dwu_match u_match (
    .item      (s1_item),
    .cfg       (cfg),
    .old_value (old_value),
    .result    (match),
    .shadow_we (shadow_we)
  );

  assign rec_next = match.rec_update ? match.rec : rec;

  // Last-hit record
  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (commit) begin
      rec <= rec_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit <= match.hit;
      out_rec <= rec_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.hit            = out_hit;
  assign rsp.last_valid     = out_rec.valid;
  assign rsp.last_source    = out_rec.source;
  assign rsp.last_slot      = out_rec.slot;
  assign rsp.last_address   = out_rec.address;
  assign rsp.last_new_value = out_rec.new_value;
  assign rsp.last_old_value = out_rec.old_value;
  assign rsp.last_is_write  = out_rec.is_write;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for debug_watchpoint_unit.
// ----------------------------------------------------------------------------
// A directed table first walks the overlap edges of the memory slots, register
// changes with and without exact match, breakpoint keys and slot priority.
// Randomized phases follow. Each phase loads a new slot setup while the unit
// is idle and then streams items aimed at the watched words, registers and
// breakpoints. Every accepted item is run through a local model of the
// comparators, the register shadow and the last-hit record. Each result is
// checked field by field against the oldest outstanding prediction. Both
// channel sides stall at random, except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import dwu_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES          = 12;
  localparam int STEADY_PHASE    = 5;
  localparam int CFG_REGS        = 6;
  localparam int IDLE_PCT        = 19;
  localparam int QUIET_LIMIT     = 1000;
  localparam int TAIL_CYCLES     = 8;
  localparam int REPORT_MAX      = 10;

  // Unused register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Memory watch kinds
  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_BOTH  = 2'd3;

  // Hit sources in the record
  localparam logic SRC_MEM = 1'b0;
  localparam logic SRC_REG = 1'b1;

  typedef struct packed {
    logic hit;
    rec_t rec;
  } status_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_HIT, ROW_MISS} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    item_t                 item;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dwu_req_if req_ch ();
  dwu_rsp_if rsp_ch ();

  debug_watchpoint_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Local copy of the slots, the shadow and the last-hit record
  logic [MEM_WATCH_W-1:0] mem_watch_cfg [SLOTS];
  logic [REG_WATCH_W-1:0] reg_watch_cfg [SLOTS];
  logic [BREAK_W-1:0]     break_cfg     [SLOTS];
  logic [31:0]            reg_shadow    [REG_COUNT];
  rec_t                   last_hit;

  status_t status_q [$];
  row_t    directed [$];
  int      mismatches = 0;
  bit      steady;
  bit      cfg_busy;
  bit      typed_on;
  logic    typed_hit;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic logic [CFG_DATA_W-1:0] mem_word(input logic [1:0] kind,
                                                     input logic [31:0] addr);
    return {4'b0, kind, addr};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_word(input logic en, input logic exact,
                                                     input logic [3:0] idx,
                                                     input logic [31:0] value);
    return {en, exact, idx, value};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] brk_word(input logic en, input logic [23:0] key);
    return {13'b0, en, key};
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                     input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind  = ROW_WRITE;
    r.index = index;
    r.data  = data;
    r.item  = '0;
    return r;
  endfunction

  function automatic row_t item_row(input row_kind_t kind, input req_kind_t op,
                                    input logic [31:0] addr, input logic [2:0] size,
                                    input logic [31:0] value, input logic [3:0] idx);
    row_t r;
    r.kind                = kind;
    r.index               = '0;
    r.data                = '0;
    r.item.req_type       = op;
    r.item.access_address = addr;
    r.item.access_size    = size;
    r.item.data_value     = value;
    r.item.reg_index      = idx;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input row_t r);
    directed.insert(directed.size(), r);
  endfunction

  // Word biased toward the ends of the address range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFC;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Register write into the local slot copy
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_t'(index))
      CFG_MEM_WATCH_0: mem_watch_cfg[0] = data[MEM_WATCH_W-1:0];
      CFG_MEM_WATCH_1: mem_watch_cfg[1] = data[MEM_WATCH_W-1:0];
      CFG_REG_WATCH_0: reg_watch_cfg[0] = data[REG_WATCH_W-1:0];
      CFG_REG_WATCH_1: reg_watch_cfg[1] = data[REG_WATCH_W-1:0];
      CFG_BREAK_0:     break_cfg[0]     = data[BREAK_W-1:0];
      CFG_BREAK_1:     break_cfg[1]     = data[BREAK_W-1:0];
      default: ;
    endcase
  endfunction

  // Hit flag and last-hit record after one item; updates shadow and record
  function automatic status_t evaluate_watch(input item_t it);
    status_t     st;
    logic [31:0] prior;
    logic [31:0] waddr;
    logic [1:0]  kind;
    logic        enabled;
    logic        is_write;
    st.hit   = 1'b0;
    is_write = (it.req_type == REQ_MEM_WRITE);
    case (req_kind_t'(it.req_type))
      REQ_MEM_WRITE, REQ_MEM_READ: begin
        for (int s = 0; s < SLOTS; s++) begin
          waddr   = mem_watch_cfg[s][31:0];
          kind    = mem_watch_cfg[s][33:32];
          enabled = is_write ? kind[1] : kind[0];
          // 33-bit sums, so nothing wraps past the top of memory
          if (!st.hit && enabled &&
              {1'b0, it.access_address} < {1'b0, waddr} + 33'(WATCH_SPAN) &&
              {1'b0, it.access_address} + {30'b0, it.access_size} > {1'b0, waddr}) begin
            st.hit   = 1'b1;
            last_hit = '{valid: 1'b1, source: SRC_MEM, slot: 1'(s), address: waddr,
                         new_value: it.data_value, old_value: 32'h0, is_write: is_write};
          end
        end
      end
      REQ_REG_UPDATE: begin
        if (int'(it.reg_index) < REG_COUNT) begin
          prior = reg_shadow[it.reg_index];
          reg_shadow[it.reg_index] = it.data_value;
          if (prior != it.data_value) begin
            for (int s = 0; s < SLOTS; s++) begin
              if (!st.hit && reg_watch_cfg[s][37] && reg_watch_cfg[s][35:32] == it.reg_index &&
                  (!reg_watch_cfg[s][36] || it.data_value == reg_watch_cfg[s][31:0])) begin
                st.hit   = 1'b1;
                last_hit = '{valid: 1'b1, source: SRC_REG, slot: 1'(s),
                             address: {28'b0, it.reg_index}, new_value: it.data_value,
                             old_value: prior, is_write: 1'b1};
              end
            end
          end
        end
      end
      default: begin
        // PC hits leave the record alone
        for (int s = 0; s < SLOTS; s++)
          if (break_cfg[s][24] && break_cfg[s][23:0] == it.access_address[25:2])
            st.hit = 1'b1;
      end
    endcase
    st.rec = last_hit;
    return st;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Random item aimed at the current slot setup
  function automatic item_t make_item();
    item_t it;
    int    s;
    s                 = $urandom_range(0, SLOTS - 1);
    it.req_type       = 2'($urandom_range(0, 3));
    it.access_address = $urandom();
    it.access_size    = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
                                                    : 3'($urandom_range(0, 7));
    it.data_value     = $urandom();
    it.reg_index      = 4'($urandom_range(0, 15));
    case (req_kind_t'(it.req_type))
      REQ_MEM_WRITE, REQ_MEM_READ: begin
        if ($urandom_range(0, 4) != 0)
          it.access_address = mem_watch_cfg[s][31:0] + 32'($urandom_range(0, 12)) - 32'd6;
      end
      REQ_REG_UPDATE: begin
        if ($urandom_range(0, 3) != 0)
          it.reg_index = reg_watch_cfg[s][35:32];
        case ($urandom_range(0, 3))
          0: it.data_value = reg_watch_cfg[s][31:0];
          1: it.data_value = reg_shadow[it.reg_index];
          2: it.data_value = pick_word();
          default: ;
        endcase
      end
      default: begin
        if ($urandom_range(0, 3) != 0)
          it.access_address[25:2] = break_cfg[s][23:0];
      end
    endcase
    return it;
  endfunction

  // Offer one item, with random gaps ahead of it, until it is taken
  task automatic send_item(input item_t it, input bit hit_known, input logic hit_value);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_on                 = hit_known;
    typed_hit                = hit_value;
    req_ch.valid             <= 1'b1;
    req_ch.req_type          <= it.req_type;
    req_ch.access_address    <= it.access_address;
    req_ch.access_size       <= it.access_size;
    req_ch.data_value        <= it.data_value;
    req_ch.reg_index         <= it.reg_index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_busy = 1'b1;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  // Result check, then register writes and prediction of accepted items
  always @(posedge clk) begin
    status_t want;
    item_t   seen;
    if (rst) begin
      foreach (mem_watch_cfg[s]) mem_watch_cfg[s] = '0;
      foreach (reg_watch_cfg[s]) reg_watch_cfg[s] = '0;
      foreach (break_cfg[s]) break_cfg[s] = '0;
      foreach (reg_shadow[r]) reg_shadow[r] = '0;
      last_hit = '0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result with no item outstanding: hit %b", rsp_ch.hit);
        end else begin
          want = status_q.pop_front();
          check_field("hit", 32'(rsp_ch.hit), 32'(want.hit));
          check_field("last_valid", 32'(rsp_ch.last_valid), 32'(want.rec.valid));
          check_field("last_source", 32'(rsp_ch.last_source), 32'(want.rec.source));
          check_field("last_slot", 32'(rsp_ch.last_slot), 32'(want.rec.slot));
          check_field("last_address", rsp_ch.last_address, want.rec.address);
          check_field("last_new_value", rsp_ch.last_new_value, want.rec.new_value);
          check_field("last_old_value", rsp_ch.last_old_value, want.rec.old_value);
          check_field("last_is_write", 32'(rsp_ch.last_is_write), 32'(want.rec.is_write));
        end
      end
      if (cfg_we)
        apply_write(cfg_index, cfg_wdata);
      if (req_ch.valid && req_ch.ready) begin
        seen.req_type       = req_ch.req_type;
        seen.access_address = req_ch.access_address;
        seen.access_size    = req_ch.access_size;
        seen.data_value     = req_ch.data_value;
        seen.reg_index      = req_ch.reg_index;
        want = evaluate_watch(seen);
        if (typed_on)
          want.hit = typed_hit;
        status_q.insert(status_q.size(), want);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no traffic
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] word;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = '0;
    req_ch.access_address = '0;
    req_ch.access_size    = '0;
    req_ch.data_value     = '0;
    req_ch.reg_index      = '0;
    steady                = 1'b0;
    cfg_busy              = 1'b0;
    typed_on              = 1'b0;
    typed_hit             = 1'b0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Setup A: write-only word, both-kind word at the top, two register watches
    add_row(write_row(CFG_MEM_WATCH_0, mem_word(KIND_WRITE, 32'h0000_1000)));
    add_row(write_row(CFG_MEM_WATCH_1, mem_word(KIND_BOTH, 32'hFFFF_FFFC)));
    add_row(write_row(CFG_REG_WATCH_0, reg_word(1'b1, 1'b0, 4'd3, 32'h0)));
    add_row(write_row(CFG_REG_WATCH_1, reg_word(1'b1, 1'b1, 4'd15, 32'hDEAD_BEEF)));
    add_row(write_row(CFG_BREAK_0, brk_word(1'b1, 24'hFF_FFFF)));
    add_row(write_row(CFG_BREAK_1, brk_word(1'b1, 24'h00_0000)));
    // breakpoint keys at both ends; PC bits outside 25:2 ignored
    add_row(item_row(ROW_HIT,  REQ_PC_CHECK, 32'h03FF_FFFC, 3'd0, 32'h0, 4'd0));
    add_row(item_row(ROW_HIT,  REQ_PC_CHECK, 32'hFC00_0003, 3'd0, 32'h0, 4'd0));
    add_row(item_row(ROW_MISS, REQ_PC_CHECK, 32'h0000_1000, 3'd0, 32'h0, 4'd0));
    // overlap edges of the watched word
    add_row(item_row(ROW_HIT,  REQ_MEM_WRITE, 32'h0000_1000, 3'd4, 32'hFFFF_FFFF, 4'd0));
    add_row(item_row(ROW_MISS, REQ_MEM_READ,  32'h0000_1000, 3'd4, 32'h1111_1111, 4'd0));
    add_row(item_row(ROW_MISS, REQ_MEM_WRITE, 32'h0000_0FFD, 3'd3, 32'h2222_2222, 4'd0));
    add_row(item_row(ROW_HIT,  REQ_MEM_WRITE, 32'h0000_0FFD, 3'd4, 32'h3333_3333, 4'd0));
    // zero size still overlaps inside the word
    add_row(item_row(ROW_HIT,  REQ_MEM_WRITE, 32'h0000_1003, 3'd0, 32'h4444_4444, 4'd0));
    add_row(item_row(ROW_MISS, REQ_MEM_WRITE, 32'h0000_1004, 3'd1, 32'h5555_5555, 4'd0));
    // top of memory: sums carry into bit 32 instead of wrapping
    add_row(item_row(ROW_HIT,  REQ_MEM_READ,  32'hFFFF_FFFF, 3'd7, 32'h6666_6666, 4'd0));
    add_row(item_row(ROW_MISS, REQ_MEM_WRITE, 32'h0000_0000, 3'd7, 32'h7777_7777, 4'd0));
    // register watches: unchanged value never fires, exact needs the match value
    add_row(item_row(ROW_MISS, REQ_REG_UPDATE, 32'h0, 3'd0, 32'h0000_0000, 4'd3));
    add_row(item_row(ROW_HIT,  REQ_REG_UPDATE, 32'h0, 3'd0, 32'hFFFF_FFFF, 4'd3));
    add_row(item_row(ROW_MISS, REQ_REG_UPDATE, 32'h0, 3'd0, 32'hFFFF_FFFF, 4'd3));
    add_row(item_row(ROW_MISS, REQ_REG_UPDATE, 32'h0, 3'd0, 32'h1234_5678, 4'd15));
    add_row(item_row(ROW_HIT,  REQ_REG_UPDATE, 32'h0, 3'd0, 32'hDEAD_BEEF, 4'd15));
    add_row(item_row(ROW_MISS, REQ_REG_UPDATE, 32'h0, 3'd0, 32'h0000_0000, 4'd15));
    // Setup B: spare indexes take no effect; slot off, breakpoint disabled
    add_row(write_row(CFG_SPARE_6, '1));
    add_row(write_row(CFG_SPARE_7, '1));
    add_row(write_row(CFG_MEM_WATCH_0, mem_word(KIND_OFF, 32'h0000_1000)));
    add_row(write_row(CFG_BREAK_0, brk_word(1'b0, 24'hFF_FFFF)));
    add_row(item_row(ROW_MISS, REQ_MEM_WRITE, 32'h0000_1000, 3'd4, 32'h8888_8888, 4'd0));
    add_row(item_row(ROW_MISS, REQ_PC_CHECK,  32'h03FF_FFFC, 3'd0, 32'h0, 4'd0));
    add_row(item_row(ROW_MISS, REQ_REG_UPDATE, 32'h0, 3'd0, 32'hFFFF_FFFF, 4'd0));
    // Setup C: both slots match, the lower one must win
    add_row(write_row(CFG_MEM_WATCH_0, mem_word(KIND_BOTH, 32'h0000_2000)));
    add_row(write_row(CFG_MEM_WATCH_1, mem_word(KIND_BOTH, 32'h0000_2000)));
    add_row(write_row(CFG_REG_WATCH_0, reg_word(1'b1, 1'b0, 4'd5, 32'h0)));
    add_row(write_row(CFG_REG_WATCH_1, reg_word(1'b1, 1'b1, 4'd5, 32'h0000_0055)));
    add_row(write_row(CFG_BREAK_1, brk_word(1'b1, 24'hFF_FFFF)));
    add_row(item_row(ROW_HIT,  REQ_MEM_READ,  32'h0000_2002, 3'd1, 32'h9999_9999, 4'd0));
    add_row(item_row(ROW_HIT,  REQ_REG_UPDATE, 32'h0, 3'd0, 32'h0000_0055, 4'd5));
    add_row(item_row(ROW_HIT,  REQ_PC_CHECK,  32'hFFFF_FFFF, 3'd0, 32'h0, 4'd0));
    add_row(item_row(ROW_ITEM, REQ_MEM_WRITE, 32'h0000_2000, 3'd5, 32'hAAAA_AAAA, 4'd0));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        if (!cfg_busy)
          wait_idle();
        write_reg(directed[i].index, directed[i].data);
      end else begin
        if (cfg_busy)
          end_writes();
        send_item(directed[i].item, directed[i].kind != ROW_ITEM, directed[i].kind == ROW_HIT);
      end
    end

    // Random phases: all-zero setup, all-ones setup, then random setups
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int r = 0; r < CFG_REGS; r++) begin
        if (ph == 0) begin
          word = '0;
        end else if (ph == 1) begin
          word = '1;
        end else begin
          case (cfg_idx_t'(r))
            CFG_MEM_WATCH_0, CFG_MEM_WATCH_1:
              word = {4'($urandom()), 2'($urandom()), pick_word()};
            CFG_REG_WATCH_0, CFG_REG_WATCH_1:
              word = {($urandom_range(0, 7) != 0), 1'($urandom()), 4'($urandom()),
                      pick_word()};
            default:
              word = {13'($urandom()), ($urandom_range(0, 7) != 0), 24'($urandom())};
          endcase
        end
        write_reg(CFG_IDX_W'(r), word);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                  {6'($urandom()), 32'($urandom())});
      end_writes();
      steady = (ph == STEADY_PHASE);
      repeat (ITEMS_PER_PHASE)
        send_item(make_item(), 1'b0, 1'b0);
    end

    steady = 1'b0;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += status_q.size();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/dwu_pkg.sv
hdl/dwu_req_if.sv
hdl/dwu_rsp_if.sv
hdl/dwu_ram.sv
hdl/dwu_shadow.sv
hdl/dwu_match.sv
hdl/debug_watchpoint_unit.sv
bench/tb.sv
